[rtl/core/ptsb_pkg.sv]
package ptsb_pkg;

   localparam int SLOTS_DEFAULT = 16;

   localparam logic [1:0] REQ_TICK   = 2'd0;
   localparam logic [1:0] REQ_ADD    = 2'd1;
   localparam logic [1:0] REQ_REMOVE = 2'd2;

   localparam logic [2:0] STATUS_FIRED    = 3'd0;
   localparam logic [2:0] STATUS_IDLE     = 3'd1;
   localparam logic [2:0] STATUS_ADDED    = 3'd2;
   localparam logic [2:0] STATUS_ADD_FAIL = 3'd3;
   localparam logic [2:0] STATUS_REMOVED  = 3'd4;
   localparam logic [2:0] STATUS_FREE     = 3'd5;

   typedef enum logic [1:0] {
      EMIT_NONE,
      EMIT_TICK_END,
      EMIT_FAIL,
      EMIT_REMOVE
   } emit_type;

   typedef struct packed {
      logic     capture;
      logic     now_inc;
      logic     scan_clear;
      logic     tick_step;
      logic     add_next;
      logic     add_claim;
      emit_type emit;
   } cmd_type;

   typedef struct packed {
      logic out_room;
      logic scan_done;
      logic add_hit;
      logic add_end;
      logic interval_zero;
   } sts_type;

endpackage

[rtl/core/periodic_timer_slot_bank_unit.sv]
// Channel   Handshake             Payload
// req       req_valid/req_stall   req_type, req_slot_index, req_interval_ms
// rsp       rsp_valid/rsp_stall   rsp_status, rsp_slot, rsp_last
//
// Tick: the scan steps one slot a cycle through the due RAM while the output register has room.
// Add: walks the used bits up to the lowest free slot.
// Remove clears the slot's used bit if set. One transaction is in the block at a time; req_stall is high meanwhile.
// Synchronous reset clears time, used bits and handshake state; no clearing pass.
// rsp_stall, while a result is waiting, holds the scan and the output register.
module periodic_timer_slot_bank_unit import ptsb_pkg::*; #(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [3:0]  req_slot_index,
   input  logic [30:0] req_interval_ms,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [3:0]  rsp_slot,
   output logic        rsp_last
);

   cmd_type cmd;
   sts_type sts;

   ptsb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_stall (req_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   ptsb_dp #(
      .SLOTS (SLOTS)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_slot_index  (req_slot_index),
      .req_interval_ms (req_interval_ms),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_slot        (rsp_slot),
      .rsp_last        (rsp_last)
   );

endmodule

[rtl/core/ptsb_ram.sv]
module ptsb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/ptsb_ctrl.sv]
module ptsb_ctrl import ptsb_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_type,
   output logic       req_stall,
   output cmd_type    cmd,
   input  sts_type    sts
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TICK,
      ST_ADD,
      ST_FAIL,
      ST_REMOVE
   } state_type;

   state_type state_ff;
   state_type state_in;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.emit = EMIT_NONE;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               case (req_type)
                  REQ_TICK: begin
                     cmd.now_inc    = 1'b1;
                     cmd.scan_clear = 1'b1;
                     state_in       = ST_TICK;
                  end
                  REQ_ADD: begin
                     cmd.scan_clear = 1'b1;
                     state_in       = ST_ADD;
                  end
                  REQ_REMOVE: begin
                     state_in = ST_REMOVE;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_TICK: begin
            if (sts.out_room) begin
               if (sts.scan_done) begin
                  cmd.emit = EMIT_TICK_END;
                  state_in = ST_IDLE;
               end else begin
                  cmd.tick_step = 1'b1;
               end
            end
         end
         ST_ADD: begin
            if (sts.interval_zero || sts.add_end) begin
               state_in = ST_FAIL;
            end else if (sts.add_hit) begin
               if (sts.out_room) begin
                  cmd.add_claim = 1'b1;
                  state_in      = ST_IDLE;
               end
            end else begin
               cmd.add_next = 1'b1;
            end
         end
         ST_FAIL: begin
            if (sts.out_room) begin
               cmd.emit = EMIT_FAIL;
               state_in = ST_IDLE;
            end
         end
         ST_REMOVE: begin
            if (sts.out_room) begin
               cmd.emit = EMIT_REMOVE;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[rtl/core/ptsb_dp.sv]
module ptsb_dp import ptsb_pkg::*; #(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [3:0]  req_slot_index,
   input  logic [30:0] req_interval_ms,
   input  cmd_type     cmd,
   output sts_type     sts,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [3:0]  rsp_slot,
   output logic        rsp_last
);

   localparam int IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW   = $clog2(SLOTS + 1);

   logic [31:0]      now_ff, now_in;
   logic [SLOTS-1:0] used_ff, used_in;
   logic [CW-1:0]    rd_idx_ff, rd_idx_in;
   logic             ev_valid_ff, ev_valid_in;
   logic [IDXW-1:0]  ev_idx_ff, ev_idx_in;
   logic             pend_valid_ff, pend_valid_in;
   logic [IDXW-1:0]  pend_idx_ff, pend_idx_in;
   logic [3:0]       idx_ff, idx_in;
   logic [30:0]      ival_ff, ival_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [2:0]       rsp_status_ff, rsp_status_in;
   logic [3:0]       rsp_slot_ff, rsp_slot_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             due_wr_en;
   logic [IDXW-1:0]  due_wr_addr;
   logic [31:0]      due_wr_data;
   logic [31:0]      due_rd_data;
   logic             per_wr_en;
   logic [30:0]      per_rd_data;
   logic             rd_en;
   logic [IDXW-1:0]  rd_addr;

   logic [IDXW-1:0]  aidx;
   logic [IDXW+3:0]  aidx_ext;
   logic [IDXW+3:0]  pend_ext;
   logic [IDXW+3:0]  rm_ext;
   logic [IDXW-1:0]  rm_idx;
   logic             rm_hit;
   logic [31:0]      diff;
   logic             fire;
   logic             at_end;

   assign aidx     = rd_idx_ff[IDXW-1:0];
   assign aidx_ext = {4'b0000, aidx};
   assign pend_ext = {4'b0000, pend_idx_ff};
   assign rm_ext   = {{IDXW{1'b0}}, idx_ff};
   assign rm_idx   = rm_ext[IDXW-1:0];
   assign rm_hit   = (rm_ext < (IDXW + 4)'(SLOTS)) && used_ff[rm_idx];
   assign at_end   = (rd_idx_ff == CW'(SLOTS));
   assign diff     = due_rd_data - now_ff;
   assign fire     = used_ff[ev_idx_ff] && ((diff == 32'd0) || diff[31]);
   assign rd_addr  = rd_idx_ff[IDXW-1:0];

   assign sts.out_room      = !rsp_valid_ff || !rsp_stall;
   assign sts.scan_done     = at_end && !ev_valid_ff;
   assign sts.add_end       = at_end;
   assign sts.add_hit       = !at_end && !used_ff[aidx];
   assign sts.interval_zero = (ival_ff == 31'd0);

   always_comb begin
      now_in        = now_ff;
      used_in       = used_ff;
      rd_idx_in     = rd_idx_ff;
      ev_valid_in   = ev_valid_ff;
      ev_idx_in     = ev_idx_ff;
      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;
      idx_in        = idx_ff;
      ival_in       = ival_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      rsp_last_in   = rsp_last_ff;
      due_wr_en     = 1'b0;
      due_wr_addr   = aidx;
      due_wr_data   = now_ff + {1'b0, ival_ff};
      per_wr_en     = 1'b0;
      rd_en         = 1'b0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd.capture) begin
         idx_in  = req_slot_index;
         ival_in = req_interval_ms;
      end

      if (cmd.now_inc) begin
         now_in = now_ff + 32'd1;
      end

      if (cmd.scan_clear) begin
         rd_idx_in     = '0;
         ev_valid_in   = 1'b0;
         pend_valid_in = 1'b0;
      end

      if (cmd.tick_step) begin
         if (!at_end) begin
            rd_en       = 1'b1;
            rd_idx_in   = rd_idx_ff + CW'(1);
            ev_valid_in = 1'b1;
            ev_idx_in   = rd_addr;
         end else begin
            ev_valid_in = 1'b0;
         end
         if (ev_valid_ff && fire) begin
            due_wr_en   = 1'b1;
            due_wr_addr = ev_idx_ff;
            due_wr_data = due_rd_data + {1'b0, per_rd_data};
            if (pend_valid_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = STATUS_FIRED;
               rsp_slot_in   = pend_ext[3:0];
               rsp_last_in   = 1'b0;
            end
            pend_valid_in = 1'b1;
            pend_idx_in   = ev_idx_ff;
         end
      end

      if (cmd.add_next) begin
         rd_idx_in = rd_idx_ff + CW'(1);
      end

      if (cmd.add_claim) begin
         used_in[aidx] = 1'b1;
         per_wr_en     = 1'b1;
         due_wr_en     = 1'b1;
         rsp_valid_in  = 1'b1;
         rsp_status_in = STATUS_ADDED;
         rsp_slot_in   = aidx_ext[3:0];
         rsp_last_in   = 1'b1;
      end

      case (cmd.emit)
         EMIT_TICK_END: begin
            rsp_valid_in = 1'b1;
            rsp_last_in  = 1'b1;
            if (pend_valid_ff) begin
               rsp_status_in = STATUS_FIRED;
               rsp_slot_in   = pend_ext[3:0];
               pend_valid_in = 1'b0;
            end else begin
               rsp_status_in = STATUS_IDLE;
               rsp_slot_in   = 4'd0;
            end
         end
         EMIT_FAIL: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = STATUS_ADD_FAIL;
            rsp_slot_in   = 4'd0;
            rsp_last_in   = 1'b1;
         end
         EMIT_REMOVE: begin
            rsp_valid_in = 1'b1;
            rsp_slot_in  = idx_ff;
            rsp_last_in  = 1'b1;
            if (rm_hit) begin
               used_in[rm_idx] = 1'b0;
               rsp_status_in   = STATUS_REMOVED;
            end else begin
               rsp_status_in = STATUS_FREE;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         now_ff        <= '0;
         used_ff       <= '0;
         rd_idx_ff     <= '0;
         ev_valid_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         now_ff        <= now_in;
         used_ff       <= used_in;
         rd_idx_ff     <= rd_idx_in;
         ev_valid_ff   <= ev_valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ev_idx_ff     <= ev_idx_in;
      pend_idx_ff   <= pend_idx_in;
      idx_ff        <= idx_in;
      ival_ff       <= ival_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_last_ff   <= rsp_last_in;
   end

   ptsb_ram #(
      .WIDTH (32),
      .DEPTH (SLOTS)
   ) u_due_ram (
      .clock   (clock),
      .wr_en   (due_wr_en),
      .wr_addr (due_wr_addr),
      .wr_data (due_wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (due_rd_data)
   );

   ptsb_ram #(
      .WIDTH (31),
      .DEPTH (SLOTS)
   ) u_period_ram (
      .clock   (clock),
      .wr_en   (per_wr_en),
      .wr_addr (aidx),
      .wr_data (ival_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (per_rd_data)
   );

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_slot   = rsp_slot_ff;
   assign rsp_last   = rsp_last_ff;

`ifndef ASSERT_OFF
   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      (cmd.tick_step || cmd.add_claim || (cmd.emit != EMIT_NONE)) |-> sts.out_room)
      else $error("result loaded without room in output register");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      rd_idx_ff <= CW'(SLOTS))
      else $error("scan index beyond slot count");

   a_now_inc: assert property (@(posedge clock) disable iff (reset)
      cmd.now_inc |=> (now_ff == $past(now_ff) + 32'd1))
      else $error("time counter did not advance on tick");

   a_scan_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_clear |=> (!pend_valid_ff && !ev_valid_ff && (rd_idx_ff == '0)))
      else $error("scan state not cleared at start of transaction");
`endif

endmodule
